@@ sv/sspg_pkg.sv @@
package sspg_pkg;

   // Field widths
   localparam int RATE_WIDTH   = 16;
   localparam int CFG_WIDTH    = 20;
   localparam int MAX_WIDTH    = 15;
   localparam int QUO_WIDTH    = 20;
   localparam int DVSR_WIDTH   = 15;
   localparam int CNT_WIDTH    = 20;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int STEP_WIDTH   = $clog2(QUO_WIDTH);

   // Register reset values
   localparam logic [CFG_WIDTH-1:0] PERIOD_NUMERATOR_RESET    = 20'd100000;
   localparam logic [MAX_WIDTH-1:0] MAX_RATE_RESET            = 15'd2000;
   localparam logic [CFG_WIDTH-1:0] HALF_STEP_THRESHOLD_RESET = 20'd8000;
   localparam logic [CFG_WIDTH-1:0] SPLIT_THRESHOLD_RESET     = 20'd1000;
   localparam logic [CFG_WIDTH-1:0] IDLE_WAIT_RESET           = 20'd1000;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_PERIOD_NUMERATOR    = 3'd0,
      CSR_MAX_RATE            = 3'd1,
      CSR_HALF_STEP_THRESHOLD = 3'd2,
      CSR_SPLIT_THRESHOLD     = 3'd3,
      CSR_IDLE_WAIT           = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_FWD  = 2'd1,
      CMD_REV  = 2'd2,
      CMD_OFF  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      SEG_START   = 2'd0,
      SEG_ON_HALF = 2'd1,
      SEG_FINAL   = 2'd2
   } seg_type;

   typedef enum logic {
      CTRL_IDLE   = 1'b0,
      CTRL_DIVIDE = 1'b1
   } ctrl_state_type;

   localparam logic REQ_TICK      = 1'b0;
   localparam logic REQ_SET_SPEED = 1'b1;

   // Timing registers seen by the step timer
   typedef struct packed {
      logic [CFG_WIDTH-1:0] half_step_threshold;
      logic [CFG_WIDTH-1:0] split_threshold;
      logic [CFG_WIDTH-1:0] idle_wait;
   } timer_cfg_type;

   // One result item
   typedef struct packed {
      cmd_type command;
      logic    half_step;
   } result_type;

   // Wait lengths of zero become one tick
   function automatic logic [CNT_WIDTH-1:0] at_least_one(input logic [CNT_WIDTH-1:0] n);
      return (n == '0) ? CNT_WIDTH'(1) : n;
   endfunction

endpackage

@@ sv/sspg_if.sv @@
interface sspg_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     req_type;
   logic signed [sspg_pkg::RATE_WIDTH-1:0]   rate;

   modport source (output valid, output req_type, output rate, input ready);
   modport sink   (input valid, input req_type, input rate, output ready);
endinterface

interface sspg_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic        half_step;

   modport source (output valid, output command, output half_step, input ready);
   modport sink   (input valid, input command, input half_step, output ready);
endinterface

@@ sv/sspg_divider.sv @@
module sspg_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [sspg_pkg::QUO_WIDTH-1:0]    dividend,
   input  logic [sspg_pkg::DVSR_WIDTH-1:0]   divisor,
   output logic                              done,
   output logic [sspg_pkg::QUO_WIDTH-1:0]    quotient
);

   logic [sspg_pkg::QUO_WIDTH-1:0]  quo_ff, quo_in;
   logic [sspg_pkg::DVSR_WIDTH-1:0] rem_ff, rem_in;
   logic [sspg_pkg::DVSR_WIDTH-1:0] dvsr_ff;
   logic [sspg_pkg::STEP_WIDTH-1:0] count_ff;
   logic                            busy_ff;
   logic                            done_ff;
   logic [sspg_pkg::DVSR_WIDTH:0]   trial;
   logic [sspg_pkg::DVSR_WIDTH:0]   diff;
   logic                            fits;

   // One restoring step: bring in the next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff, quo_ff[sspg_pkg::QUO_WIDTH-1]};
      diff   = trial - {1'b0, dvsr_ff};
      fits   = (trial >= {1'b0, dvsr_ff});
      rem_in = fits ? diff[sspg_pkg::DVSR_WIDTH-1:0] : trial[sspg_pkg::DVSR_WIDTH-1:0];
      quo_in = {quo_ff[sspg_pkg::QUO_WIDTH-2:0], fits};
   end

   // Control: load on start, count quotient bits, pulse done
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= sspg_pkg::STEP_WIDTH'(sspg_pkg::QUO_WIDTH - 1);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dvsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ sv/sspg_timer.sv @@
module sspg_timer (
   input  logic                             clock,
   input  logic                             reset,
   input  sspg_pkg::timer_cfg_type          cfg,
   input  logic                             period_wr,
   input  logic                             period_neg,
   input  logic [sspg_pkg::QUO_WIDTH-1:0]   period_mag,
   input  logic                             tick,
   output sspg_pkg::result_type             result
);

   logic                            neg_ff;
   logic [sspg_pkg::QUO_WIDTH-1:0]  mag_ff;
   logic [sspg_pkg::CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [sspg_pkg::CNT_WIDTH-1:0]  off_ff, off_in;
   sspg_pkg::seg_type               seg_ff, seg_in;
   logic                            half;
   logic [sspg_pkg::CNT_WIDTH-1:0]  step_time;
   logic [sspg_pkg::CNT_WIDTH-1:0]  split_half;

   // Step mode from the current period
   always_comb begin
      half       = (mag_ff >= cfg.half_step_threshold);
      step_time  = half ? {1'b0, mag_ff[sspg_pkg::QUO_WIDTH-1:1]} : mag_ff;
      split_half = sspg_pkg::at_least_one({1'b0, step_time[sspg_pkg::CNT_WIDTH-1:1]});
   end

   // Advance the wait on a tick, start a cycle or emit the off command
   always_comb begin
      result.command   = sspg_pkg::CMD_NONE;
      result.half_step = 1'b0;
      cnt_in           = cnt_ff;
      off_in           = off_ff;
      seg_in           = seg_ff;
      if (tick) begin
         if (cnt_ff > sspg_pkg::CNT_WIDTH'(1)) begin
            cnt_in = cnt_ff - 1'b1;
         end else if (seg_ff == sspg_pkg::SEG_ON_HALF) begin
            result.command = sspg_pkg::CMD_OFF;
            cnt_in         = off_ff;
            seg_in         = sspg_pkg::SEG_FINAL;
         end else if (mag_ff == '0) begin
            result.command = sspg_pkg::CMD_OFF;
            cnt_in         = sspg_pkg::at_least_one(cfg.idle_wait);
            seg_in         = sspg_pkg::SEG_FINAL;
         end else begin
            result.command   = neg_ff ? sspg_pkg::CMD_REV : sspg_pkg::CMD_FWD;
            result.half_step = half;
            if (step_time > cfg.split_threshold) begin
               cnt_in = split_half;
               off_in = split_half;
               seg_in = sspg_pkg::SEG_ON_HALF;
            end else begin
               cnt_in = sspg_pkg::at_least_one(step_time);
               seg_in = sspg_pkg::SEG_FINAL;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ff <= 1'b0;
         mag_ff <= '0;
         cnt_ff <= '0;
         off_ff <= '0;
         seg_ff <= sspg_pkg::SEG_START;
      end else begin
         cnt_ff <= cnt_in;
         off_ff <= off_in;
         seg_ff <= seg_in;
         if (period_wr) begin
            neg_ff <= period_neg;
            mag_ff <= period_mag;
         end
      end
   end

endmodule

@@ sv/stepper_speed_pulse_generator_top.sv @@
// Result: a result item is registered as its input item is accepted.
// Flow: after a tick or a set-speed item that stops or is out of range, the input is held
// only while a result item waits unaccepted; a set-speed item with an accepted nonzero rate
// also holds it while the bit-serial divider produces one of the 20 quotient bits per cycle.
// Reset: synchronous, active high; registers return to defaults, motor stopped, no
// clearing pass.
module stepper_speed_pulse_generator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   sspg_req_if.sink                             req,
   sspg_rsp_if.source                           rsp,
   input  logic                                 csr_wr_en,
   input  logic [sspg_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [sspg_pkg::CFG_WIDTH-1:0]       csr_data
);

   logic [sspg_pkg::CFG_WIDTH-1:0] period_numerator_ff;
   logic [sspg_pkg::MAX_WIDTH-1:0] max_rate_ff;
   sspg_pkg::timer_cfg_type        timer_cfg_ff;

   sspg_pkg::ctrl_state_type       state_ff, state_in;
   logic                           neg_ff;
   logic                           rsp_valid_ff;
   sspg_pkg::result_type           rsp_data_ff;

   logic                           accept;
   logic                           is_set;
   logic                           rate_neg;
   logic [sspg_pkg::RATE_WIDTH-1:0] rate_mag;
   logic                           rate_zero;
   logic                           rate_ok;
   logic                           div_start;
   logic                           div_done;
   logic [sspg_pkg::QUO_WIDTH-1:0] quotient;
   logic                           period_wr;
   logic [sspg_pkg::QUO_WIDTH-1:0] period_mag;
   sspg_pkg::result_type           tick_result;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_numerator_ff              <= sspg_pkg::PERIOD_NUMERATOR_RESET;
         max_rate_ff                      <= sspg_pkg::MAX_RATE_RESET;
         timer_cfg_ff.half_step_threshold <= sspg_pkg::HALF_STEP_THRESHOLD_RESET;
         timer_cfg_ff.split_threshold     <= sspg_pkg::SPLIT_THRESHOLD_RESET;
         timer_cfg_ff.idle_wait           <= sspg_pkg::IDLE_WAIT_RESET;
      end else if (csr_wr_en) begin
         case (sspg_pkg::csr_index_type'(csr_index))
            sspg_pkg::CSR_PERIOD_NUMERATOR:    period_numerator_ff <= csr_data;
            sspg_pkg::CSR_MAX_RATE:
               max_rate_ff <= csr_data[sspg_pkg::MAX_WIDTH-1:0];
            sspg_pkg::CSR_HALF_STEP_THRESHOLD: timer_cfg_ff.half_step_threshold <= csr_data;
            sspg_pkg::CSR_SPLIT_THRESHOLD:     timer_cfg_ff.split_threshold <= csr_data;
            sspg_pkg::CSR_IDLE_WAIT:           timer_cfg_ff.idle_wait <= csr_data;
            default: ;
         endcase
      end
   end

   // Decode the incoming item
   always_comb begin
      accept    = req.valid & req.ready;
      is_set    = (req.req_type == sspg_pkg::REQ_SET_SPEED);
      rate_neg  = req.rate[sspg_pkg::RATE_WIDTH-1];
      rate_mag  = rate_neg ? (~req.rate + 1'b1) : req.rate;
      rate_zero = (req.rate == '0);
      rate_ok   = (rate_mag <= {1'b0, max_rate_ff});
      div_start = accept & is_set & ~rate_zero & rate_ok;
      period_wr  = div_done | (accept & is_set & rate_zero);
      period_mag = div_done ? quotient : '0;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sspg_pkg::CTRL_IDLE:   if (div_start) state_in = sspg_pkg::CTRL_DIVIDE;
         sspg_pkg::CTRL_DIVIDE: if (div_done) state_in = sspg_pkg::CTRL_IDLE;
         default:               state_in = sspg_pkg::CTRL_IDLE;
      endcase
   end

   // Outputs of the state machine
   always_comb begin
      case (state_ff)
         sspg_pkg::CTRL_IDLE: req.ready = ~rsp_valid_ff | rsp.ready;
         default:             req.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sspg_pkg::CTRL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the sign and the result payload
   always_ff @(posedge clock) begin
      if (div_start) begin
         neg_ff <= rate_neg;
      end
      if (accept) begin
         rsp_data_ff <= tick_result;
      end
   end

   sspg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (period_numerator_ff),
      .divisor  (rate_mag[sspg_pkg::DVSR_WIDTH-1:0]),
      .done     (div_done),
      .quotient (quotient)
   );

   sspg_timer u_timer (
      .clock      (clock),
      .reset      (reset),
      .cfg        (timer_cfg_ff),
      .period_wr  (period_wr),
      .period_neg (neg_ff),
      .period_mag (period_mag),
      .tick       (accept & ~is_set),
      .result     (tick_result)
   );

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.command   = rsp_data_ff.command;
   assign rsp.half_step = rsp_data_ff.half_step;

endmodule

@@ tb/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES     = 6;
   localparam int SETTLE_CYCLES    = 30;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int LONG_HOLD_AFTER  = 90;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int MAX_REPORTS      = 10;
   localparam int SMALL_PHASE      = 80;

   typedef struct {
      logic                                   req_type;
      logic signed [sspg_pkg::RATE_WIDTH-1:0] rate;
   } speed_item_type;

   logic                               clock;
   logic                               reset;
   logic                               csr_wr_en;
   logic [sspg_pkg::CSR_IDX_WIDTH-1:0] csr_index;
   logic [sspg_pkg::CFG_WIDTH-1:0]     csr_data;

   sspg_req_if req_ch();
   sspg_rsp_if rsp_ch();

   stepper_speed_pulse_generator_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Register copies and motor state of the predictor
   logic [sspg_pkg::CFG_WIDTH-1:0] numerator_reg;
   logic [sspg_pkg::MAX_WIDTH-1:0] max_rate_reg;
   logic [sspg_pkg::CFG_WIDTH-1:0] half_thr_reg;
   logic [sspg_pkg::CFG_WIDTH-1:0] split_thr_reg;
   logic [sspg_pkg::CFG_WIDTH-1:0] idle_wait_reg;
   int                             motor_period;
   int                             latched_period;
   logic [sspg_pkg::CNT_WIDTH-1:0] ticks_left;
   logic [sspg_pkg::CNT_WIDTH-1:0] off_half_ticks;
   sspg_pkg::seg_type              motor_seg;

   speed_item_type       pending_items[$];
   sspg_pkg::result_type cmd_expected[$];

   logic           offering;
   speed_item_type cur_item;
   int             gap_left;
   int             burst_left;
   int             items_accepted;

   int   stall_mode;
   int   mode_left;
   int   hold_left;
   logic hold_done;

   int mismatches;
   int cycle_count;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Wait length in ticks, never shorter than one tick
   function automatic logic [sspg_pkg::CNT_WIDTH-1:0] wait_ticks(input int n);
      return (n == 0) ? sspg_pkg::CNT_WIDTH'(1) : sspg_pkg::CNT_WIDTH'(n);
   endfunction

   // Advance the motor by one accepted item and queue the command it yields
   task automatic advance_motor(input speed_item_type it);
      sspg_pkg::result_type res;
      int                   r;
      int                   mag;
      int                   quo;
      int                   step_ticks;
      logic                 half;
      res.command   = sspg_pkg::CMD_NONE;
      res.half_step = 1'b0;
      if (it.req_type == sspg_pkg::REQ_SET_SPEED) begin
         r   = int'(it.rate);
         mag = (r < 0) ? -r : r;
         if (r == 0) begin
            motor_period = 0;
         end else if (mag <= int'(max_rate_reg)) begin
            quo          = int'(numerator_reg) / mag;
            motor_period = (r < 0) ? -quo : quo;
         end
      end else if (ticks_left > 1) begin
         ticks_left = ticks_left - 1'b1;
      end else if (motor_seg == sspg_pkg::SEG_ON_HALF) begin
         // second half of a split step
         res.command = sspg_pkg::CMD_OFF;
         ticks_left  = off_half_ticks;
         motor_seg   = sspg_pkg::SEG_FINAL;
      end else begin
         // cycle start: latch the period
         latched_period = motor_period;
         if (latched_period == 0) begin
            res.command = sspg_pkg::CMD_OFF;
            ticks_left  = wait_ticks(int'(idle_wait_reg));
            motor_seg   = sspg_pkg::SEG_FINAL;
         end else begin
            mag           = (latched_period < 0) ? -latched_period : latched_period;
            half          = (mag >= int'(half_thr_reg));
            step_ticks    = half ? mag / 2 : mag;
            res.command   = (latched_period > 0) ? sspg_pkg::CMD_FWD : sspg_pkg::CMD_REV;
            res.half_step = half;
            if (step_ticks > int'(split_thr_reg)) begin
               off_half_ticks = wait_ticks(step_ticks / 2);
               ticks_left     = off_half_ticks;
               motor_seg      = sspg_pkg::SEG_ON_HALF;
            end else begin
               ticks_left = wait_ticks(step_ticks);
               motor_seg  = sspg_pkg::SEG_FINAL;
            end
         end
      end
      cmd_expected.push_back(res);
   endtask

   // Sender: bursts of items with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid    <= 1'b0;
         req_ch.req_type <= sspg_pkg::REQ_TICK;
         req_ch.rate     <= '0;
         offering         = 1'b0;
         cur_item         = '{sspg_pkg::REQ_TICK, '0};
         gap_left         = 0;
         burst_left       = $urandom_range(30, 1);
      end else begin
         if (offering && req_ch.ready) begin
            advance_motor(cur_item);
            items_accepted++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() > 0) begin
               cur_item = pending_items.pop_front();
               offering = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(30, 1);
                  gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
               end
            end
         end
         req_ch.valid    <= offering;
         req_ch.req_type <= cur_item.req_type;
         req_ch.rate     <= cur_item.rate;
      end
   end

   // Receiver: stall pattern in random stretches, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_mode    = 0;
         mode_left     = 0;
         hold_left     = 0;
         hold_done     = 1'b0;
      end else begin
         if (!hold_done && items_accepted >= LONG_HOLD_AFTER) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(2);
            mode_left  = $urandom_range(50, 1);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(1));
               default: rsp_ch.ready <= ($urandom_range(3) == 0);
            endcase
         end
      end
   end

   // Compare each result item with the oldest expected command
   always @(posedge clock) begin : result_monitor
      sspg_pkg::result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (cmd_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected result item: command %0d half_step %0d",
                        rsp_ch.command, rsp_ch.half_step);
            end
         end else begin
            want = cmd_expected.pop_front();
            if (rsp_ch.command !== want.command || rsp_ch.half_step !== want.half_step) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display({"result mismatch: expected command %0d half_step %0d, ",
                            "got command %0d half_step %0d"},
                           want.command, want.half_step, rsp_ch.command, rsp_ch.half_step);
               end
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_reg(input sspg_pkg::csr_index_type idx,
                            input logic [sspg_pkg::CFG_WIDTH-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
   endtask

   // Write all registers; upper data bits of the rate limit are random and dropped
   task automatic load_settings(input logic [sspg_pkg::CFG_WIDTH-1:0] num,
                                input logic [sspg_pkg::MAX_WIDTH-1:0] max_rate,
                                input logic [sspg_pkg::CFG_WIDTH-1:0] half_thr,
                                input logic [sspg_pkg::CFG_WIDTH-1:0] split_thr,
                                input logic [sspg_pkg::CFG_WIDTH-1:0] idle_wait);
      logic [sspg_pkg::CFG_WIDTH-1:0] max_word;
      max_word                          = sspg_pkg::CFG_WIDTH'($urandom);
      max_word[sspg_pkg::MAX_WIDTH-1:0] = max_rate;
      write_reg(sspg_pkg::CSR_PERIOD_NUMERATOR, num);
      write_reg(sspg_pkg::CSR_MAX_RATE, max_word);
      write_reg(sspg_pkg::CSR_HALF_STEP_THRESHOLD, half_thr);
      write_reg(sspg_pkg::CSR_SPLIT_THRESHOLD, split_thr);
      write_reg(sspg_pkg::CSR_IDLE_WAIT, idle_wait);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      numerator_reg = num;
      max_rate_reg  = max_word[sspg_pkg::MAX_WIDTH-1:0];
      half_thr_reg  = half_thr;
      split_thr_reg = split_thr;
      idle_wait_reg = idle_wait;
   endtask

   task automatic load_small_settings();
      load_settings(sspg_pkg::CFG_WIDTH'($urandom_range(80, 1)),
                    sspg_pkg::MAX_WIDTH'($urandom_range(40, 1)),
                    sspg_pkg::CFG_WIDTH'($urandom_range(60, 1)),
                    sspg_pkg::CFG_WIDTH'($urandom_range(25, 1)),
                    sspg_pkg::CFG_WIDTH'($urandom_range(12, 1)));
   endtask

   // Hold until every item is taken and every expected result has come
   task automatic wait_drained();
      while (pending_items.size() != 0 || offering || cmd_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_ticks(input int n);
      speed_item_type it;
      repeat (n) begin
         it.req_type = sspg_pkg::REQ_TICK;
         it.rate     = sspg_pkg::RATE_WIDTH'($urandom);
         pending_items.push_back(it);
      end
   endtask

   task automatic push_speed(input int r);
      speed_item_type it;
      it.req_type = sspg_pkg::REQ_SET_SPEED;
      it.rate     = sspg_pkg::RATE_WIDTH'(r);
      pending_items.push_back(it);
   endtask

   // Mostly ticks; set-speed rates cluster inside the accepted range
   function automatic speed_item_type random_item();
      speed_item_type it;
      int             lim;
      int             mag;
      lim         = int'(max_rate_reg);
      it.req_type = sspg_pkg::REQ_TICK;
      it.rate     = sspg_pkg::RATE_WIDTH'($urandom);
      if ($urandom_range(99) < 22) begin
         it.req_type = sspg_pkg::REQ_SET_SPEED;
         case ($urandom_range(9))
            0: it.rate = '0;
            1: it.rate = sspg_pkg::RATE_WIDTH'($urandom);
            2: begin
               mag     = (lim < 32767) ? lim + 1 : lim;
               it.rate = sspg_pkg::RATE_WIDTH'($urandom_range(1) ? -mag : mag);
            end
            3: begin
               case ($urandom_range(3))
                  0: it.rate = sspg_pkg::RATE_WIDTH'(32767);
                  1: it.rate = sspg_pkg::RATE_WIDTH'(-32768);
                  2: it.rate = sspg_pkg::RATE_WIDTH'(-32767);
                  default: it.rate = sspg_pkg::RATE_WIDTH'($urandom_range(1) ? -1 : 1);
               endcase
            end
            default: begin
               if (lim == 0) begin
                  it.rate = '0;
               end else begin
                  mag     = int'($urandom_range(lim, 1));
                  it.rate = sspg_pkg::RATE_WIDTH'($urandom_range(1) ? -mag : mag);
               end
            end
         endcase
      end
      return it;
   endfunction

   task automatic random_phase(input int count);
      repeat (count) pending_items.push_back(random_item());
   endtask

   initial begin
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      reset     = 1'b1;

      numerator_reg  = sspg_pkg::PERIOD_NUMERATOR_RESET;
      max_rate_reg   = sspg_pkg::MAX_RATE_RESET;
      half_thr_reg   = sspg_pkg::HALF_STEP_THRESHOLD_RESET;
      split_thr_reg  = sspg_pkg::SPLIT_THRESHOLD_RESET;
      idle_wait_reg  = sspg_pkg::IDLE_WAIT_RESET;
      motor_period   = 0;
      latched_period = 0;
      ticks_left     = '0;
      off_half_ticks = '0;
      motor_seg      = sspg_pkg::SEG_START;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: rejected rates, the rate limit, divides by the full numerator, stop
      push_speed(2001);
      push_speed(-32768);
      push_speed(-2000);
      push_speed(1);
      push_speed(0);
      wait_drained();

      // Short periods: stopped start, quotient of zero, split and unsplit steps
      load_settings(12, 32767, 8, 2, 1);
      push_ticks(1);
      push_speed(32767);
      push_speed(3);
      push_ticks(4);
      push_speed(-1);
      push_ticks(6);
      push_speed(-5);
      push_ticks(2);
      push_speed(0);
      push_ticks(2);
      wait_drained();

      // Random phases; the first pauses halfway until drained
      load_small_settings();
      random_phase(SMALL_PHASE / 2);
      wait_drained();
      random_phase(SMALL_PHASE / 2);
      wait_drained();

      load_settings(1, 1, 1, 1, 1);
      random_phase(60);
      wait_drained();

      load_small_settings();
      random_phase(SMALL_PHASE);
      wait_drained();

      // All registers zero: of the set-speed items, only stop is accepted
      load_settings(0, 0, 0, 0, 0);
      random_phase(40);
      wait_drained();

      // Zero thresholds and idle wait: half steps, one-tick waits
      load_settings(30, 30, 0, 0, 0);
      random_phase(70);
      wait_drained();

      repeat (3) begin
         load_small_settings();
         random_phase(SMALL_PHASE);
         wait_drained();
      end

      load_small_settings();
      random_phase(80);
      wait_drained();

      // Large values in every register last, since a stop here waits very long
      load_settings(1000000, 32767, 1000000, 1000000, 1000000);
      random_phase(60);
      wait_drained();

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
